[rtl/lap3_pkg.sv]
package lap3_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned DATA_W    = 3 * CHAN_W;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 4;

    // Default frame store limits for the top level parameters.
    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(480);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = CFG_IDX_W'(0),
        REG_FRAME_HEIGHT = CFG_IDX_W'(1)
    } cfg_reg_t;

    // Meaning of the input request's tuser bit.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // One RGB pixel, red in the lowest bits.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // Per-result neighbourhood control handed from the sequencer to the kernel.
    typedef struct packed {
        logic par;         // row parity of the centre pixel, selects the line store
        logic up_en;       // upper neighbour lies inside the frame
        logic dn_en;       // lower neighbour lies inside the frame
        logic lf_en;       // left neighbour lies inside the frame
        logic rt_en;       // right neighbour lies inside the frame
        logic fwd_centre;  // centre pixel is the one arriving with this request
        logic fwd_right;   // right neighbour is the one arriving with this request
        logic last;        // result belongs to the final pixel of the frame
    } win_ctl_t;

endpackage

[rtl/laplacian_3x3_rgb_filter_top.sv]
// Result path: the request that brings a pixel's lower neighbour (or, for the last row of a
// frame, the flush request that drains it) is registered in stage 1, then in the output register.
// Throughput: one request per cycle while the result stream is not stalled.
// Reset: aresetn is synchronous and active low; it clears positions, the drain flag and the
// pipeline valid flags and restores the default frame size. Line stores are not cleared.
module laplacian_3x3_rgb_filter_top #(
    parameter int unsigned MAX_WIDTH  = lap3_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = lap3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input pixel stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lap3_pkg::DATA_W-1:0]    s_tdata,   // red_in, green_in, blue_in
    input  logic                           s_tuser,   // action
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lap3_pkg::DATA_W-1:0]    m_tdata,   // red_out, green_out, blue_out
    output logic                           m_tlast,   // last_of_frame
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lap3_pkg::CFG_W-1:0]     cfg_data
);
    import lap3_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
    localparam int unsigned POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // Last valid index for a programmed size: zero acts as one, large values saturate.
    function automatic int unsigned dim_last(input logic [CFG_W-1:0] v, input int unsigned lim);
        int unsigned val;
        val = 32'(v);
        if (val == 0) begin
            return 0;
        end else if (val > lim) begin
            return lim - 1;
        end
        return val - 1;
    endfunction

    // Frame size, kept as last column and last row index.
    logic [COL_W-1:0] wlast_reg, wlast_next;
    logic [ROW_W-1:0] hlast_reg, hlast_next;

    // Input side position: the pixel that the next pixel request writes.
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [POS_W-1:0] in_pos_reg, in_pos_next;

    // Output side position: the pixel whose result is due next.
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;

    // Set once the whole frame is in and results of the last row are still owed.
    logic drain_reg, drain_next;

    // Stage 1: line store read data plus the request that caused it.
    logic     st1_valid_reg;
    win_ctl_t st1_ctl_reg;
    pixel_t   st1_pix_reg;

    // Output register and the centre of the previous result (left neighbour).
    logic   m_valid_reg;
    pixel_t m_data_reg;
    logic   m_last_reg;
    pixel_t left_reg;

    logic     accept;
    logic     is_pix;
    logic     emit;
    logic     in_last;
    logic     out_last;
    logic     st1_move;
    win_ctl_t ctl_new;
    pixel_t   in_pix;

    logic             wr_en;
    logic [COL_W-1:0] rd_addr_b;
    pixel_t           even_a, even_b, odd_a, odd_b;
    pixel_t           res_pix, ctr_pix;

    // Stage 1 moves on whenever the output register is free or is being emptied.
    assign st1_move  = !m_valid_reg || m_tready;
    assign s_tready  = !st1_valid_reg || st1_move;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign in_pix    = pixel_t'(s_tdata);

    assign in_last  = (in_col_reg == wlast_reg) && (in_row_reg == hlast_reg);
    assign out_last = (out_col_reg == wlast_reg) && (out_row_reg == hlast_reg);
    // A pixel request during the drain carries no pixel and counts as a flush.
    assign is_pix   = (s_tuser == ACT_PIXEL) && !drain_reg;

    // Right neighbour address; at the row end it is masked, so any address does.
    assign rd_addr_b = (out_col_reg == wlast_reg) ? '0 : out_col_reg + 1'b1;

    // Request sequencing. A pixel that completes the lower neighbour of the due result, the
    // final pixel of the frame, or a flush during the drain releases exactly one result.
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_pos_next  = in_pos_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_pos_next = out_pos_reg;
        drain_next   = drain_reg;
        wr_en        = 1'b0;
        emit         = 1'b0;

        ctl_new            = '0;
        ctl_new.par        = out_row_reg[0];
        ctl_new.up_en      = (out_row_reg != '0);
        ctl_new.dn_en      = (out_row_reg != hlast_reg);
        ctl_new.lf_en      = (out_col_reg != '0);
        ctl_new.rt_en      = (out_col_reg != wlast_reg);
        ctl_new.fwd_centre = is_pix && (out_pos_reg == in_pos_reg);
        ctl_new.fwd_right  = is_pix && ((out_pos_reg + 1'b1) == in_pos_reg);
        ctl_new.last       = out_last;

        if (accept) begin
            if (is_pix) begin
                wr_en = 1'b1;
                if (in_last) begin
                    in_col_next = '0;
                    in_row_next = '0;
                    in_pos_next = '0;
                    drain_next  = 1'b1;
                    emit        = 1'b1;
                end else begin
                    in_pos_next = in_pos_reg + 1'b1;
                    if (in_col_reg == wlast_reg) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + 1'b1;
                    end else begin
                        in_col_next = in_col_reg + 1'b1;
                    end
                    // From the second row on, each pixel is the lower neighbour of the result
                    // one row above it.
                    emit = (in_row_reg != '0);
                end
            end else begin
                // A flush outside the drain is dropped without a result.
                emit = drain_reg;
            end

            if (emit) begin
                if (out_last) begin
                    out_col_next = '0;
                    out_row_next = '0;
                    out_pos_next = '0;
                    drain_next   = 1'b0;
                end else begin
                    out_pos_next = out_pos_reg + 1'b1;
                    if (out_col_reg == wlast_reg) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Frame size registers. Writes must arrive only while the block is idle; the block does not enforce it.
    always_comb begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  wlast_next = COL_W'(dim_last(cfg_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: hlast_next = ROW_W'(dim_last(cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg     <= COL_W'(dim_last(RST_FRAME_WIDTH, MAX_WIDTH));
            hlast_reg     <= ROW_W'(dim_last(RST_FRAME_HEIGHT, MAX_HEIGHT));
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_pos_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_pos_reg   <= '0;
            drain_reg     <= 1'b0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            wlast_reg   <= wlast_next;
            hlast_reg   <= hlast_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_pos_reg  <= in_pos_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_pos_reg <= out_pos_next;
            drain_reg   <= drain_next;
            // An accepted request always finds stage 1 empty or leaving.
            if (accept) begin
                st1_valid_reg <= emit;
            end else if (st1_move) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_move) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            st1_ctl_reg <= ctl_new;
            st1_pix_reg <= in_pix;
        end
        if (st1_valid_reg && st1_move) begin
            m_data_reg <= res_pix;
            m_last_reg <= st1_ctl_reg.last;
            left_reg   <= ctr_pix;
        end
    end

    // Rows alternate between two line stores by parity. The store that receives the current
    // row still holds the row two above, which is the upper neighbour of the due result; its
    // old contents come back because the read precedes the write at the same address.
    lap3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_even_line (
        .aclk      (aclk),
        .wr_en     (wr_en && !in_row_reg[0]),
        .wr_addr   (in_col_reg),
        .wr_data   (s_tdata),
        .rd_en     (accept && emit),
        .rd_addr_a (out_col_reg),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (even_a),
        .rd_data_b (even_b)
    );

    lap3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_odd_line (
        .aclk      (aclk),
        .wr_en     (wr_en && in_row_reg[0]),
        .wr_addr   (in_col_reg),
        .wr_data   (s_tdata),
        .rd_en     (accept && emit),
        .rd_addr_a (out_col_reg),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (odd_a),
        .rd_data_b (odd_b)
    );

    // The kernel combines the store reads, the arriving pixel and the previous centre.
    lap3_kernel u_kernel (
        .ctl        (st1_ctl_reg),
        .in_pix     (st1_pix_reg),
        .even_a     (even_a),
        .even_b     (even_b),
        .odd_a      (odd_a),
        .odd_b      (odd_b),
        .left_pix   (left_reg),
        .result     (res_pix),
        .centre_pix (ctr_pix)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[rtl/lap3_ram.sv]
module lap3_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[rtl/lap3_kernel.sv]
module lap3_kernel (
    input  lap3_pkg::win_ctl_t ctl,
    input  lap3_pkg::pixel_t   in_pix,
    input  lap3_pkg::pixel_t   even_a,
    input  lap3_pkg::pixel_t   even_b,
    input  lap3_pkg::pixel_t   odd_a,
    input  lap3_pkg::pixel_t   odd_b,
    input  lap3_pkg::pixel_t   left_pix,
    output lap3_pkg::pixel_t   result,
    output lap3_pkg::pixel_t   centre_pix
);
    import lap3_pkg::*;

    // Four neighbours minus four times the centre, clamped to the channel range.
    function automatic logic [CHAN_W-1:0] lap_chan(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] u,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] l,
        input logic [CHAN_W-1:0] r
    );
        logic [CHAN_W+1:0] nsum;
        logic [CHAN_W+1:0] c4;
        logic [CHAN_W+1:0] diff;
        nsum = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
        c4   = {c, 2'b00};
        diff = nsum - c4;
        if (nsum < c4) begin
            return '0;
        end else if (diff[CHAN_W+1:CHAN_W] != 2'b00) begin
            return '1;
        end
        return diff[CHAN_W-1:0];
    endfunction

    pixel_t centre;
    pixel_t up_m;
    pixel_t dn_m;
    pixel_t lf_m;
    pixel_t rt_m;
    pixel_t right;

    always_comb begin
        centre = ctl.fwd_centre ? in_pix : (ctl.par ? odd_a : even_a);
        right  = ctl.fwd_right  ? in_pix : (ctl.par ? odd_b : even_b);
        up_m   = ctl.up_en ? (ctl.par ? even_a : odd_a) : '0;
        dn_m   = ctl.dn_en ? in_pix   : '0;
        lf_m   = ctl.lf_en ? left_pix : '0;
        rt_m   = ctl.rt_en ? right    : '0;
    end

    assign result.red   = lap_chan(centre.red,   up_m.red,   dn_m.red,   lf_m.red,   rt_m.red);
    assign result.green = lap_chan(centre.green, up_m.green, dn_m.green, lf_m.green,
                                   rt_m.green);
    assign result.blue  = lap_chan(centre.blue,  up_m.blue,  dn_m.blue,  lf_m.blue,  rt_m.blue);
    assign centre_pix   = centre;

endmodule

[rtl/lap3_checker.sv]
module lap3_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lap3_pkg::DATA_W-1:0] m_tdata,
    input logic                        m_tlast
);
    import lap3_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // With the output register empty the input side is never blocked.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output register empty");

    // A new result follows an accepted request through stage 1 and the output register.
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a request");

    // Once a result is taken and nothing stands behind it, the output goes empty.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !$past(s_tvalid && s_tready)
            && !$past(m_tvalid && !m_tready) |=> !m_tvalid)
        else $error("result repeated");

endmodule

bind laplacian_3x3_rgb_filter_top lap3_checker u_lap3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
